@@ sv/ttpe_pkg.sv @@
// Package for the IPA text to phone events block: types, codes and code point tables.
package ttpe_pkg;

  localparam int unsigned OffsetWidthDefault = 16;
  localparam int unsigned TokDepth = 4;
  localparam int unsigned OutDepth = 8;
  localparam int unsigned MaxRes = 4;

  localparam logic [7:0] NoPhone = 8'hFF;
  localparam logic [5:0] PhA  = 6'd0;
  localparam logic [5:0] PhO  = 6'd6;
  localparam logic [5:0] PhAi = 6'd10;
  localparam logic [5:0] PhAu = 6'd11;
  localparam logic [5:0] PhOi = 6'd12;
  localparam logic [5:0] PhT  = 6'd15;
  localparam logic [5:0] PhD  = 6'd16;
  localparam logic [5:0] PhM  = 6'd31;
  localparam logic [5:0] PhN  = 6'd32;
  localparam logic [5:0] PhNg = 6'd34;
  localparam logic [5:0] PhJ  = 6'd40;
  localparam logic [5:0] PhCh = 6'd41;
  localparam logic [5:0] PhSp = 6'd42;
  localparam logic [5:0] PhPp = 6'd43;

  localparam logic [6:0] FlSyl  = 7'h01;
  localparam logic [6:0] FlLong = 7'h08;
  localparam logic [6:0] FlWend = 7'h10;
  localparam logic [6:0] FlPend = 7'h20;
  localparam logic [6:0] FlQ    = 7'h40;

  localparam logic [7:0] DurNormal = 8'd100;
  localparam logic [7:0] DurComma  = 8'd165;
  localparam logic [7:0] DurLong   = 8'd150;
  localparam logic [7:0] DurHalf   = 8'd125;
  localparam logic [7:0] DurDash   = 8'd120;
  localparam logic [7:0] DurShort  = 8'd50;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_UTF8  = 3'd1,
    ST_UNK   = 3'd2,
    ST_MANY  = 3'd3,
    ST_EMPTY = 3'd4
  } ttpe_status_e;

  typedef enum logic [2:0] {
    LK_NONE = 3'd0,
    LK_T    = 3'd1,
    LK_D    = 3'd2,
    LK_A    = 3'd3,
    LK_O    = 3'd4
  } ttpe_lk_e;

  typedef enum logic [1:0] {
    CFG_NO_AUTOPAUSE = 2'd0,
    CFG_PERMISSIVE   = 2'd1,
    CFG_EVENT_LIMIT  = 2'd2
  } ttpe_cfg_e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       byte_present;
    logic       end_of_text;
  } ttpe_in_t;

  typedef struct packed {
    logic        item_kind;
    logic [5:0]  phone_code;
    logic [6:0]  flag_bits;
    logic [7:0]  dur_pct;
    logic [2:0]  status;
    logic [15:0] error_offset;
    logic [20:0] err_cp;
    logic [15:0] event_total;
    logic        last;
  } ttpe_res_t;

  // One decoded request from the front: a code point, a UTF-8 error and/or end of text.
  typedef struct packed {
    logic        pt;
    logic        err;
    logic        eot;
    logic [20:0] cp;
  } ttpe_tok_t;

  function automatic logic tie_mark(input logic [20:0] u);
    return u == 21'h0361 || u == 21'h035C || u == 21'h200D;
  endfunction

  function automatic logic quiet_mark(input logic [20:0] u);
    return u == 21'h5F || u == 21'h00B7 || u == 21'h2027 || u == 21'h2060 ||
           u == 21'hFEFF || u == 21'h032F || u == 21'h0311 || u == 21'h034F ||
           u == 21'hFE0E || u == 21'hFE0F;
  endfunction

  function automatic logic blank_mark(input logic [20:0] u);
    return u == 21'h20 || u == 21'h09 || u == 21'h00A0 || u == 21'h2009 || u == 21'h202F;
  endfunction

  function automatic logic [7:0] phone_lookup(input logic [20:0] u);
    logic [7:0] ph;
    case (u)
      21'h61, 21'h0250:                 ph = 8'd0;
      21'h65:                           ph = 8'd1;
      21'h0259, 21'h025C, 21'h025D:     ph = 8'd2;
      21'h025B:                         ph = 8'd3;
      21'h69:                           ph = 8'd4;
      21'h026A:                         ph = 8'd5;
      21'h6F:                           ph = 8'd6;
      21'h0254:                         ph = 8'd7;
      21'h75:                           ph = 8'd8;
      21'h028A:                         ph = 8'd9;
      21'h70:                           ph = 8'd13;
      21'h62, 21'h0253:                 ph = 8'd14;
      21'h74:                           ph = 8'd15;
      21'h64, 21'h0257:                 ph = 8'd16;
      21'h6B, 21'h71:                   ph = 8'd17;
      21'h67, 21'h0261, 21'h0260:       ph = 8'd18;
      21'h0294:                         ph = 8'd19;
      21'h66, 21'h0278:                 ph = 8'd20;
      21'h76:                           ph = 8'd21;
      21'h03B2:                         ph = 8'd22;
      21'h73:                           ph = 8'd23;
      21'h7A:                           ph = 8'd24;
      21'h03B8:                         ph = 8'd25;
      21'h00F0:                         ph = 8'd26;
      21'h0283, 21'h00E7, 21'h0255:     ph = 8'd27;
      21'h78, 21'h03C7:                 ph = 8'd28;
      21'h0263:                         ph = 8'd29;
      21'h68, 21'h0266:                 ph = 8'd30;
      21'h6D:                           ph = 8'd31;
      21'h6E:                           ph = 8'd32;
      21'h0272, 21'h0144:               ph = 8'd33;
      21'h014B:                         ph = 8'd34;
      21'h6C:                           ph = 8'd35;
      21'h72, 21'h0280:                 ph = 8'd36;
      21'h027E:                         ph = 8'd37;
      21'h77, 21'h028B:                 ph = 8'd38;
      21'h6A, 21'h0265, 21'h029D, 21'h028E: ph = 8'd39;
      21'h025F, 21'h02A4, 21'h0292:     ph = 8'd40;
      21'h02A7:                         ph = 8'd41;
      default:                          ph = NoPhone;
    endcase
    return ph;
  endfunction

endpackage

@@ sv/ipa_text_to_phone_events_top.sv @@
// Requests are registered in the token queue and results in the result queue.
// Throughput: one text byte per cycle while full is low; the back takes one request
// per cycle whenever the result queue has room for four results, so bursts stall it.
// Reset: asynchronous, active low; empties both queues, clears all per-text state and
// returns the registers to their defaults (autopause on, strict, event limit 1024).
module ipa_text_to_phone_events_top import ttpe_pkg::*; #(
  parameter int unsigned OffsetWidth = OffsetWidthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  ttpe_in_t    in_data_i,
  output logic        empty,
  input  logic        pop,
  output ttpe_res_t   out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  localparam int unsigned TokW = $bits(ttpe_tok_t) + OffsetWidth;

  logic tok_wr, tok_empty, tok_take, room;
  ttpe_tok_t tok_in, tok_out;
  logic [OffsetWidth-1:0] at_in, at_out;
  logic [2:0] wr_n;
  ttpe_res_t [MaxRes-1:0] wr_items;

  assign cfg_ready_o = 1'b1;

  ttpe_front #(.OffsetWidth(OffsetWidth)) u_front (
    .clk_i, .rst_ni,
    .acc_i    (push && !full),
    .in_i     (in_data_i),
    .tok_wr_o (tok_wr),
    .tok_o    (tok_in),
    .tok_at_o (at_in)
  );

  ttpe_fifo #(.Width(TokW), .Depth(TokDepth)) u_tokq (
    .clk_i, .rst_ni,
    .wr_i    (tok_wr),
    .wdata_i ({tok_in, at_in}),
    .full_o  (full),
    .rd_i    (tok_take),
    .rdata_o ({tok_out, at_out}),
    .empty_o (tok_empty)
  );

  ttpe_back #(.OffsetWidth(OffsetWidth)) u_back (
    .clk_i, .rst_ni,
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i,
    .cfg_data_i,
    .tok_valid_i (!tok_empty),
    .tok_i       (tok_out),
    .tok_at_i    (at_out),
    .out_ready_i (room),
    .tok_take_o  (tok_take),
    .wr_n_o      (wr_n),
    .wr_items_o  (wr_items)
  );

  ttpe_outq #(.Depth(OutDepth)) u_outq (
    .clk_i, .rst_ni,
    .wr_n_i     (wr_n),
    .wr_items_i (wr_items),
    .room_o     (room),
    .rd_i       (pop),
    .rdata_o    (out_data_o),
    .empty_o    (empty)
  );
endmodule

@@ sv/ttpe_fifo.sv @@
// Small first-in first-out queue for decoded requests between front and back.
module ttpe_fifo import ttpe_pkg::*; #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             rd_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic do_wr, do_rd;

  assign full_o  = cnt_q == CntW'(Depth);
  assign empty_o = cnt_q == '0;
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end
endmodule

@@ sv/ttpe_front.sv @@
// Front part: byte offsets and strict UTF-8 decoding into code point requests.
module ttpe_front import ttpe_pkg::*; #(
  parameter int unsigned OffsetWidth = OffsetWidthDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   acc_i,
  input  ttpe_in_t               in_i,
  output logic                   tok_wr_o,
  output ttpe_tok_t              tok_o,
  output logic [OffsetWidth-1:0] tok_at_o
);
  logic [20:0] part_q, part_d;
  logic [1:0] rem_q, rem_d;
  logic [7:0] lead_q, lead_d;
  logic [OffsetWidth-1:0] seq_q, seq_d, off_q, off_d;
  logic [1:0] need;
  logic [7:0] b;
  logic bad;

  assign b = in_i.text_byte;

  always_comb begin
    part_d   = part_q;
    rem_d    = rem_q;
    lead_d   = lead_q;
    seq_d    = seq_q;
    off_d    = off_q;
    tok_o    = '0;
    tok_at_o = '0;
    tok_wr_o = 1'b0;
    need = (lead_q >= 8'hF0) ? 2'd3 : (lead_q >= 8'hE0) ? 2'd2 : 2'd1;
    bad  = (b[7:6] != 2'b10) ||
           (rem_q == need &&
            ((lead_q == 8'hE0 && b < 8'hA0) || (lead_q == 8'hED && b >= 8'hA0) ||
             (lead_q == 8'hF0 && b < 8'h90) || (lead_q == 8'hF4 && b >= 8'h90)));
    if (acc_i) begin
      if (in_i.byte_present) begin
        off_d = off_q + 1'b1;
        if (rem_q == 2'd0) begin
          seq_d = off_q;
          if (b < 8'h80) begin
            tok_o.pt = 1'b1;
            tok_o.cp = {13'd0, b};
            tok_at_o = off_q;
          end else if (b >= 8'hC2 && b <= 8'hDF) begin
            rem_d  = 2'd1;
            part_d = {16'd0, b[4:0]};
            lead_d = b;
          end else if (b >= 8'hE0 && b <= 8'hEF) begin
            rem_d  = 2'd2;
            part_d = {17'd0, b[3:0]};
            lead_d = b;
          end else if (b >= 8'hF0 && b <= 8'hF4) begin
            rem_d  = 2'd3;
            part_d = {18'd0, b[2:0]};
            lead_d = b;
          end else begin
            tok_o.err = 1'b1;
            tok_at_o  = off_q;
          end
        end else if (bad) begin
          tok_o.err = 1'b1;
          tok_at_o  = seq_q;
          rem_d     = 2'd0;
        end else begin
          part_d = {part_q[14:0], b[5:0]};
          rem_d  = rem_q - 1'b1;
          if (rem_d == 2'd0) begin
            tok_o.pt = 1'b1;
            tok_o.cp = part_d;
            tok_at_o = seq_q;
          end
        end
      end
      if (in_i.end_of_text) begin
        tok_o.eot = 1'b1;
        // A sequence cut off by the end of text fails at its first byte.
        if (!tok_o.err && rem_d != 2'd0) begin
          tok_o.err = 1'b1;
          tok_at_o  = seq_d;
        end
        part_d = '0;
        rem_d  = '0;
        lead_d = '0;
        seq_d  = '0;
        off_d  = '0;
      end
      tok_wr_o = tok_o.pt || tok_o.err || tok_o.eot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      part_q <= '0;
      rem_q  <= '0;
      lead_q <= '0;
      seq_q  <= '0;
      off_q  <= '0;
    end else begin
      part_q <= part_d;
      rem_q  <= rem_d;
      lead_q <= lead_d;
      seq_q  <= seq_d;
      off_q  <= off_d;
    end
  end
endmodule

@@ sv/ttpe_back.sv @@
// Back part: lookahead joining, held event, marks, pauses, limits and final status.
module ttpe_back import ttpe_pkg::*; #(
  parameter int unsigned OffsetWidth = OffsetWidthDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  input  logic [1:0]             cfg_index_i,
  input  logic [15:0]            cfg_data_i,
  input  logic                   tok_valid_i,
  input  ttpe_tok_t              tok_i,
  input  logic [OffsetWidth-1:0] tok_at_i,
  input  logic                   out_ready_i,
  output logic                   tok_take_o,
  output logic [2:0]             wr_n_o,
  output ttpe_res_t [MaxRes-1:0] wr_items_o
);
  typedef struct packed {
    logic [2:0]             lk;
    logic                   tie;
    logic [OffsetWidth-1:0] lko;
    logic                   hv;
    logic [5:0]             hp;
    logic [6:0]             hf;
    logic [7:0]             hd;
    logic [1:0]             ps;
    logic                   saw;
    logic [15:0]            cnt;
    logic                   halt;
  } st_t;

  typedef struct packed {
    st_t                    s;
    ttpe_res_t [MaxRes-1:0] items;
    logic [2:0]             n;
    logic                   failed;
    logic                   ok;
  } ctx_t;

  st_t st_q, st_d;
  ctx_t c;
  logic no_autopause_q, permissive_q;
  logic [15:0] limit_q;

  function automatic ctx_t f_emit(input ctx_t ci, input ttpe_res_t r);
    ctx_t co;
    co = ci;
    if (co.n < 3'(MaxRes)) begin
      co.items[co.n[1:0]] = r;
      co.n = co.n + 1'b1;
    end
    return co;
  endfunction

  function automatic ctx_t f_put_held(input ctx_t ci);
    ctx_t co;
    ttpe_res_t r;
    co = ci;
    r = '0;
    r.phone_code = co.s.hp;
    r.flag_bits  = co.s.hf;
    r.dur_pct    = co.s.hd;
    if (co.s.hv) begin
      co = f_emit(co, r);
    end
    return co;
  endfunction

  function automatic ctx_t f_fail(input ctx_t ci, input ttpe_status_e st,
                                  input logic [OffsetWidth-1:0] at, input logic [20:0] u);
    ctx_t co;
    ttpe_res_t r;
    co = f_put_held(ci);
    co.s.hv = 1'b0;
    r = '0;
    r.item_kind    = 1'b1;
    r.status       = st;
    r.error_offset = 16'(at);
    r.err_cp       = u;
    r.event_total  = co.s.cnt;
    r.last         = 1'b1;
    co = f_emit(co, r);
    co.s.halt = 1'b1;
    co.failed = 1'b1;
    return co;
  endfunction

  function automatic ctx_t f_push_raw(input ctx_t ci, input logic [5:0] ph,
                                      input logic [6:0] fl, input logic [7:0] pct);
    ctx_t co;
    co = ci;
    co.ok = 1'b0;
    if (co.s.cnt < limit_q) begin
      co = f_put_held(co);
      co.s.hv  = 1'b1;
      co.s.hp  = ph;
      co.s.hf  = fl;
      co.s.hd  = pct;
      co.s.cnt = co.s.cnt + 1'b1;
      co.ok    = 1'b1;
    end
    return co;
  endfunction

  function automatic ctx_t f_push_sound(input ctx_t ci, input logic [5:0] ph,
                                        input logic [OffsetWidth-1:0] at,
                                        input logic [20:0] u);
    ctx_t co;
    logic [6:0] fl;
    co = ci;
    fl = '0;
    // Pending stress lands only on vowels.
    if (ph <= PhOi && co.s.ps != 2'd0) begin
      fl = {4'd0, co.s.ps, 1'b0};
      co.s.ps = 2'd0;
    end
    co = f_push_raw(co, ph, fl, DurNormal);
    if (!co.ok) begin
      co = f_fail(co, ST_MANY, at, u);
    end else begin
      co.s.saw = 1'b1;
    end
    return co;
  endfunction

  function automatic ctx_t f_pause(input ctx_t ci, input logic [5:0] ph,
                                   input logic [6:0] fl, input logic [7:0] pct);
    ctx_t co;
    co = ci;
    co.ok = 1'b1;
    if (co.s.hv) begin
      if (co.s.hp >= PhSp) begin
        // Merge into the held pause; a phrase pause wins over a short one.
        if (ph == PhPp) begin
          co.s.hp = PhPp;
          co.s.hf = co.s.hf | fl;
        end
        if (pct > co.s.hd) begin
          co.s.hd = pct;
        end
      end else begin
        co = f_push_raw(co, ph, fl, pct);
      end
    end
    return co;
  endfunction

  function automatic logic [20:0] f_look_char(input logic [2:0] k);
    return (k == LK_T) ? 21'h74 : (k == LK_D) ? 21'h64 : (k == LK_A) ? 21'h61 : 21'h6F;
  endfunction

  function automatic ctx_t f_resolve(input ctx_t ci);
    ctx_t co;
    logic [2:0] k;
    logic [5:0] ph;
    co = ci;
    k = co.s.lk;
    co.s.lk  = LK_NONE;
    co.s.tie = 1'b0;
    co.ok    = 1'b1;
    ph = (k == LK_T) ? PhT : (k == LK_D) ? PhD : (k == LK_A) ? PhA : PhO;
    if (k >= LK_T && k <= LK_O) begin
      co = f_push_sound(co, ph, co.s.lko, f_look_char(k));
    end
    return co;
  endfunction

  function automatic ctx_t f_utf8_fail(input ctx_t ci, input logic [OffsetWidth-1:0] at);
    ctx_t co;
    co = ci;
    // A t or d with a tie behind it is dropped rather than pushed.
    if ((co.s.lk == LK_T || co.s.lk == LK_D) && co.s.tie) begin
      co.s.lk  = LK_NONE;
      co.s.tie = 1'b0;
      co = f_fail(co, ST_UTF8, at, 21'd0);
    end else begin
      co = f_resolve(co);
      if (co.ok) begin
        co = f_fail(co, ST_UTF8, at, 21'd0);
      end
    end
    return co;
  endfunction

  function automatic ctx_t f_take_point(input ctx_t ci, input logic [20:0] u,
                                        input logic [OffsetWidth-1:0] at);
    ctx_t co;
    logic [2:0] k;
    logic [7:0] joined;
    logic [7:0] ph;
    logic done;
    co = ci;
    k = co.s.lk;
    done = 1'b0;
    joined = NoPhone;
    if (k != LK_NONE) begin
      if ((k == LK_T || k == LK_D) && !co.s.tie && tie_mark(u)) begin
        co.s.tie = 1'b1;
        done = 1'b1;
      end else begin
        if (k == LK_T && (u == 21'h0283 || u == 21'h00E7)) joined = {2'd0, PhCh};
        else if (k == LK_D && u == 21'h0292) joined = {2'd0, PhJ};
        else if (k == LK_A && u == 21'h026A) joined = {2'd0, PhAi};
        else if (k == LK_A && u == 21'h028A) joined = {2'd0, PhAu};
        else if (k == LK_O && u == 21'h026A) joined = {2'd0, PhOi};
        if (joined != NoPhone) begin
          co.s.lk  = LK_NONE;
          co.s.tie = 1'b0;
          co = f_push_sound(co, joined[5:0], co.s.lko, f_look_char(k));
          done = 1'b1;
        end else begin
          co = f_resolve(co);
          done = !co.ok;
        end
      end
    end
    ph = phone_lookup(u);
    if (!done) begin
      if (u == 21'h0329) begin
        if (co.s.hv && (co.s.hp == PhM || co.s.hp == PhN || co.s.hp == PhNg)) begin
          co.s.hf = co.s.hf | FlSyl | {4'd0, co.s.ps, 1'b0};
          co.s.ps = 2'd0;
          if (co.s.hd < DurHalf) co.s.hd = DurHalf;
        end
      end else if (quiet_mark(u) || tie_mark(u)) begin
        co.ok = 1'b1;
      end else if (u == 21'h02C8) begin
        co.s.ps = 2'd1;
      end else if (u == 21'h02CC) begin
        if (!co.s.ps[0]) co.s.ps = co.s.ps | 2'd2;
      end else if (u == 21'h02D0 || u == 21'h02D1) begin
        if (co.s.hv && co.s.hp < PhSp) begin
          co.s.hf = co.s.hf | FlLong;
          co.s.hd = (u == 21'h02D0) ? DurLong : DurHalf;
        end
      end else if (blank_mark(u)) begin
        if (!no_autopause_q) begin
          if (co.s.hv && co.s.hp < PhSp) co.s.hf = co.s.hf | FlWend;
          co = f_pause(co, PhSp, 7'd0, DurShort);
          if (!co.ok) co = f_fail(co, ST_MANY, at, u);
        end
      end else if (u == 21'h0A || u == 21'h0D || u == 21'h2E || u == 21'h21 ||
                   u == 21'h3F || u == 21'h3B || u == 21'h3A || u == 21'h2014) begin
        co = f_pause(co, PhPp, FlPend | ((u == 21'h3F) ? FlQ : 7'd0), DurNormal);
        if (!co.ok) co = f_fail(co, ST_MANY, at, u);
        else co.s.ps = 2'd0;
      end else if (u == 21'h2C || u == 21'h2013 || u == 21'h2F) begin
        co = f_pause(co, PhSp, 7'd0, (u == 21'h2C) ? DurComma : DurDash);
        if (!co.ok) co = f_fail(co, ST_MANY, at, u);
      end else if (u == 21'h74 || u == 21'h64 || u == 21'h61 || u == 21'h6F) begin
        co.s.lk  = (u == 21'h74) ? LK_T : (u == 21'h64) ? LK_D : (u == 21'h61) ? LK_A : LK_O;
        co.s.tie = 1'b0;
        co.s.lko = at;
      end else if (ph == NoPhone) begin
        if (!permissive_q) co = f_fail(co, ST_UNK, at, u);
      end else begin
        co = f_push_sound(co, ph[5:0], at, u);
      end
    end
    return co;
  endfunction

  function automatic ctx_t f_finish(input ctx_t ci);
    ctx_t co;
    ttpe_res_t r;
    co = f_resolve(ci);
    if (co.ok) begin
      // One trailing short pause is dropped and uncounted.
      if (co.s.hv && co.s.hp == PhSp) begin
        co.s.hv  = 1'b0;
        co.s.cnt = co.s.cnt - 1'b1;
      end else begin
        co = f_put_held(co);
        co.s.hv = 1'b0;
      end
      r = '0;
      r.item_kind    = 1'b1;
      r.status       = co.s.saw ? ST_OK : ST_EMPTY;
      r.error_offset = 16'hFFFF;
      r.event_total  = co.s.cnt;
      r.last         = 1'b1;
      co = f_emit(co, r);
    end
    return co;
  endfunction

  assign tok_take_o = tok_valid_i && out_ready_i;

  always_comb begin
    c = '0;
    c.s = st_q;
    if (tok_take_o) begin
      if (st_q.halt) begin
        if (tok_i.eot) c.s = '0;
      end else begin
        if (tok_i.pt) c = f_take_point(c, tok_i.cp, tok_at_i);
        if (tok_i.err && !c.failed) c = f_utf8_fail(c, tok_at_i);
        if (tok_i.eot) begin
          if (!c.failed) c = f_finish(c);
          c.s = '0;
        end
      end
    end
    st_d       = c.s;
    wr_n_o     = c.n;
    wr_items_o = c.items;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q           <= '0;
      no_autopause_q <= 1'b0;
      permissive_q   <= 1'b0;
      limit_q        <= 16'd1024;
    end else begin
      st_q <= st_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_NO_AUTOPAUSE: no_autopause_q <= cfg_data_i[0];
          CFG_PERMISSIVE:   permissive_q   <= cfg_data_i[0];
          CFG_EVENT_LIMIT:  limit_q        <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // A halted text emits nothing until its end.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_take_o && st_q.halt |-> wr_n_o == 3'd0)
    else $error("halted text produced results");

  // The end of a text leaves no held event and no halt behind.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_take_o && tok_i.eot |=> !st_q.hv && !st_q.halt)
    else $error("state not cleared at end of text");

  // Entering the halted state always writes a final status item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_take_o && !st_q.halt && st_d.halt |->
      wr_n_o != 3'd0 && wr_items_o[2'(wr_n_o - 3'd1)].last)
    else $error("halt without final status");
endmodule

@@ sv/ttpe_outq.sv @@
// Result queue: takes up to four results per cycle from the back, hands out one per pop.
module ttpe_outq import ttpe_pkg::*; #(
  parameter int unsigned Depth = OutDepth
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [2:0]             wr_n_i,
  input  ttpe_res_t [MaxRes-1:0] wr_items_i,
  output logic                   room_o,
  input  logic                   rd_i,
  output ttpe_res_t              rdata_o,
  output logic                   empty_o
);
  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  ttpe_res_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic do_rd;

  assign empty_o = cnt_q == '0;
  assign room_o  = cnt_q <= CntW'(Depth - MaxRes);
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];
  assign cnt_d   = cnt_q + CntW'(wr_n_i) - CntW'(do_rd);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(wr_n_i);
      rd_ptr_q <= rd_ptr_q + PtrW'(do_rd);
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxRes; i++) begin
      if (3'(i) < wr_n_i) begin
        mem_q[wr_ptr_q + PtrW'(i)] <= wr_items_i[i];
      end
    end
  end
endmodule
